// ===== src/mpf_pkg.sv =====
package mpf_pkg;

    localparam int LIMB_W = 64;
    localparam int FE_W   = 256;
    localparam int CELL_W = 64;
    localparam int NCELL  = 5;
    localparam int SW     = NCELL * CELL_W;
    localparam int CNT_W  = 8;

    localparam logic [FE_W-1:0] PRIME = {
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFE_FFFF_FC2F
    };
    localparam logic [FE_W-1:0] MONT_ONE = {{(FE_W-33){1'b0}}, 33'h1_0000_03D1};

    localparam logic [2:0] OP_NEG = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_SQR = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

// ===== src/mpf_in_if.sv =====
interface mpf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;

    modport source (
        output valid, operation, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3,
        input  ready
    );
    modport sink (
        input  valid, operation, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3,
        output ready
    );
endinterface

// ===== src/mpf_out_if.sv =====
interface mpf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] c_limb0;
    logic [63:0] c_limb1;
    logic [63:0] c_limb2;
    logic [63:0] c_limb3;

    modport source (
        output valid, c_limb0, c_limb1, c_limb2, c_limb3,
        input  ready
    );
    modport sink (
        input  valid, c_limb0, c_limb1, c_limb2, c_limb3,
        output ready
    );
endinterface

// ===== src/montgomery_prime_field_alu.sv =====
// Arithmetic unit over the secp256k1 field p = 2^256 - 2^32 - 977, operands in
// Montgomery form (R = 2^256) as four little-endian 64-bit limbs. One result per
// request transfer. Negate and unused codes compute as the request is accepted; add
// and subtract register a raw sum, then correct it by p in ST_FIX; multiply, square
// and power run on the multiplier. Every result then passes through the output
// register. The multiplier is a bit-serial Montgomery row: five 64-bit cells that
// absorb one multiplier bit per cycle, then a final conditional subtract.
// Power runs square-and-multiply over all 256 exponent bits on that single row.
// The block takes one request at a time; a new request transfers while a finished
// result still waits in the output register.
module montgomery_prime_field_alu (
    input  logic      clk,
    input  logic      rst_n,
    mpf_in_if.sink    req,
    mpf_out_if.source rsp
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIX   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_PSTEP = 6'b001000,
        ST_PACC  = 6'b010000,
        ST_PBASE = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [2:0]                   op_reg;
    logic [mpf_pkg::FE_W:0]       tmp_reg;
    logic [mpf_pkg::FE_W-1:0]     acc_reg;
    logic [mpf_pkg::FE_W-1:0]     base_reg;
    logic [mpf_pkg::FE_W-1:0]     exp_reg;
    logic [mpf_pkg::CNT_W-1:0]    bit_reg;
    logic [mpf_pkg::FE_W-1:0]     res_reg;
    logic                         res_valid_reg;
    logic [mpf_pkg::FE_W-1:0]     out_reg;
    logic                         out_valid_reg;

    logic [mpf_pkg::FE_W-1:0]     a_w;
    logic [mpf_pkg::FE_W-1:0]     b_w;
    logic                         accept;
    logic                         mul_start;
    logic [mpf_pkg::FE_W-1:0]     mul_x;
    logic [mpf_pkg::FE_W-1:0]     mul_y;
    mpf_pkg::mul_status_t         mul_st;
    logic [mpf_pkg::FE_W-1:0]     mul_r;
    logic [mpf_pkg::FE_W+1:0]     add_diff;
    logic [mpf_pkg::FE_W-1:0]     fix_res;
    logic                         out_load;

    assign a_w = {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
    assign b_w = {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};

    // Hold requests while an operation runs or a computed result has nowhere to go.
    assign req.ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept    = req.valid && req.ready;

    assign out_load = res_valid_reg && (!out_valid_reg || rsp.ready);

    assign rsp.valid   = out_valid_reg;
    assign rsp.c_limb0 = out_reg[63:0];
    assign rsp.c_limb1 = out_reg[127:64];
    assign rsp.c_limb2 = out_reg[191:128];
    assign rsp.c_limb3 = out_reg[255:192];

    // In ST_FIX, add and subtract finish with a conditional correction by p.
    assign add_diff = {1'b0, tmp_reg} - {2'b00, mpf_pkg::PRIME};
    always_comb
    begin
        if (op_reg == mpf_pkg::OP_ADD)
        begin
            fix_res = add_diff[mpf_pkg::FE_W+1] ? tmp_reg[mpf_pkg::FE_W-1:0]
                                                : add_diff[mpf_pkg::FE_W-1:0];
        end
        else
        begin
            fix_res = tmp_reg[mpf_pkg::FE_W] ? tmp_reg[mpf_pkg::FE_W-1:0] + mpf_pkg::PRIME
                                             : tmp_reg[mpf_pkg::FE_W-1:0];
        end
    end

    // Steer the multiplier: direct requests, then the power schedule.
    always_comb
    begin
        mul_start = 1'b0;
        mul_x     = base_reg;
        mul_y     = base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mul_x     = a_w;
                mul_y     = (req.operation == mpf_pkg::OP_SQR) ? a_w : b_w;
                mul_start = accept && ((req.operation == mpf_pkg::OP_MUL) ||
                                       (req.operation == mpf_pkg::OP_SQR));
            end
            ST_PSTEP:
            begin
                mul_start = 1'b1;
                if (exp_reg[0])
                begin
                    mul_x = acc_reg;
                end
            end
            ST_PACC:
            begin
                mul_start = mul_st.done;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    mpf_mont u_mont (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .status (mul_st),
        .r      (mul_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        mpf_pkg::OP_ADD: state_next = ST_FIX;
                        mpf_pkg::OP_SUB: state_next = ST_FIX;
                        mpf_pkg::OP_MUL: state_next = ST_MUL;
                        mpf_pkg::OP_SQR: state_next = ST_MUL;
                        mpf_pkg::OP_POW: state_next = ST_PSTEP;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIX:   state_next = ST_IDLE;
            ST_MUL:   if (mul_st.done) state_next = ST_IDLE;
            ST_PSTEP: state_next = exp_reg[0] ? ST_PACC : ST_PBASE;
            ST_PACC:  if (mul_st.done) state_next = ST_PBASE;
            ST_PBASE:
            begin
                if (mul_st.done)
                begin
                    state_next = (bit_reg == {mpf_pkg::CNT_W{1'b1}}) ? ST_IDLE : ST_PSTEP;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                bit_reg       <= '0;
                res_valid_reg <= (req.operation == mpf_pkg::OP_NEG) ||
                                 (req.operation > mpf_pkg::OP_POW);
            end
            else if (state_reg == ST_FIX)
            begin
                res_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_MUL) && mul_st.done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_PBASE) && mul_st.done)
            begin
                bit_reg       <= bit_reg + 1'b1;
                res_valid_reg <= (bit_reg == {mpf_pkg::CNT_W{1'b1}});
            end
            else if (out_load)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        if (accept)
        begin
            op_reg   <= req.operation;
            acc_reg  <= mpf_pkg::MONT_ONE;
            base_reg <= a_w;
            exp_reg  <= b_w;
            case (req.operation)
                mpf_pkg::OP_NEG: res_reg <= (a_w == '0) ? '0 : mpf_pkg::PRIME - a_w;
                mpf_pkg::OP_ADD: tmp_reg <= {1'b0, a_w} + {1'b0, b_w};
                mpf_pkg::OP_SUB: tmp_reg <= {1'b0, a_w} - {1'b0, b_w};
                default:         res_reg <= '0;
            endcase
        end
        else
        begin
            case (state_reg)
                ST_FIX:
                begin
                    res_reg <= fix_res;
                end
                ST_MUL:
                begin
                    if (mul_st.done)
                    begin
                        res_reg <= mul_r;
                    end
                end
                ST_PACC:
                begin
                    if (mul_st.done)
                    begin
                        acc_reg <= mul_r;
                    end
                end
                ST_PBASE:
                begin
                    if (mul_st.done)
                    begin
                        base_reg <= mul_r;
                        exp_reg  <= {1'b0, exp_reg[mpf_pkg::FE_W-1:1]};
                        res_reg  <= acc_reg;
                    end
                end
                default:
                begin
                    res_reg <= res_reg;
                end
            endcase
        end
    end
endmodule

// ===== src/mpf_cell.sv =====
// One slice of the running Montgomery sum: add, then shift right by one bit.
module mpf_cell (
    input  logic                        clk,
    input  logic                        clr,
    input  logic                        en,
    input  logic [mpf_pkg::CELL_W-1:0]  addend,
    input  logic                        cin,
    input  logic                        shin,
    output logic                        cout,
    output logic                        sum0,
    output logic [mpf_pkg::CELL_W-1:0]  slice
);
    logic [mpf_pkg::CELL_W-1:0] slice_reg;
    logic [mpf_pkg::CELL_W:0]   sum;

    assign sum   = {1'b0, slice_reg} + {1'b0, addend} + {{mpf_pkg::CELL_W{1'b0}}, cin};
    assign cout  = sum[mpf_pkg::CELL_W];
    assign sum0  = sum[0];
    assign slice = slice_reg;

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            slice_reg <= '0;
        end
        else if (en)
        begin
            slice_reg <= {shin, sum[mpf_pkg::CELL_W-1:1]};
        end
    end
endmodule

// ===== src/mpf_mont.sv =====
// Bit-serial Montgomery multiplier: r = x*y/2^256 mod p, one conditional subtract.
module mpf_mont (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mpf_pkg::FE_W-1:0]   x,
    input  logic [mpf_pkg::FE_W-1:0]   y,
    output mpf_pkg::mul_status_t       status,
    output logic [mpf_pkg::FE_W-1:0]   r
);
    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_RUN  = 3'b010,
        MS_FIX  = 3'b100
    } mstate_t;

    mstate_t                      state_reg, state_next;
    logic [mpf_pkg::CNT_W-1:0]    cnt_reg;
    logic [mpf_pkg::FE_W-1:0]     x_reg;
    logic [mpf_pkg::FE_W-1:0]     y_reg;
    logic [mpf_pkg::FE_W:0]       bp_reg;

    logic [mpf_pkg::SW-1:0]       s_w;
    logic [mpf_pkg::SW-1:0]       addend_w;
    logic [mpf_pkg::NCELL-1:0]    cin_w;
    logic [mpf_pkg::NCELL-1:0]    cout_w;
    logic [mpf_pkg::NCELL-1:0]    sum0_w;
    logic [mpf_pkg::NCELL-1:0]    shin_w;
    logic                         xi;
    logic                         q;
    logic                         run;
    logic                         go;
    logic [mpf_pkg::FE_W:0]       t_w;
    logic [mpf_pkg::FE_W+1:0]     diff_w;

    assign run = (state_reg == MS_RUN);
    assign go  = start && ((state_reg == MS_IDLE) || (state_reg == MS_FIX));
    assign xi  = x_reg[0];
    assign q   = s_w[0] ^ (xi & y_reg[0]);

    always_comb
    begin
        case ({xi, q})
            2'b11:   addend_w = {{(mpf_pkg::SW-mpf_pkg::FE_W-1){1'b0}}, bp_reg};
            2'b10:   addend_w = {{(mpf_pkg::SW-mpf_pkg::FE_W){1'b0}}, y_reg};
            2'b01:   addend_w = {{(mpf_pkg::SW-mpf_pkg::FE_W){1'b0}}, mpf_pkg::PRIME};
            default: addend_w = '0;
        endcase
    end

    assign cin_w  = {cout_w[mpf_pkg::NCELL-2:0], 1'b0};
    assign shin_w = {1'b0, sum0_w[mpf_pkg::NCELL-1:1]};

    for (genvar k = 0; k < mpf_pkg::NCELL; k++)
    begin : g_cell
        mpf_cell u_cell (
            .clk    (clk),
            .clr    (go),
            .en     (run),
            .addend (addend_w[k*mpf_pkg::CELL_W +: mpf_pkg::CELL_W]),
            .cin    (cin_w[k]),
            .shin   (shin_w[k]),
            .cout   (cout_w[k]),
            .sum0   (sum0_w[k]),
            .slice  (s_w[k*mpf_pkg::CELL_W +: mpf_pkg::CELL_W])
        );
    end

    // The sum never reaches the top cell's carry, so that carry is masked to zero in the final check.
    assign t_w    = s_w[mpf_pkg::FE_W:0] | {{mpf_pkg::FE_W{1'b0}}, cout_w[mpf_pkg::NCELL-1] & 1'b0};
    assign diff_w = {1'b0, t_w} - {2'b00, mpf_pkg::PRIME};
    assign r      = diff_w[mpf_pkg::FE_W+1] ? t_w[mpf_pkg::FE_W-1:0]
                                            : diff_w[mpf_pkg::FE_W-1:0];

    assign status.busy = (state_reg != MS_IDLE);
    assign status.done = (state_reg == MS_FIX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MS_IDLE: if (go) state_next = MS_RUN;
            MS_RUN:  if (cnt_reg == {mpf_pkg::CNT_W{1'b1}}) state_next = MS_FIX;
            MS_FIX:  state_next = go ? MS_RUN : MS_IDLE;
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                cnt_reg <= '0;
            end
            else if (run)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg  <= x;
            y_reg  <= y;
            bp_reg <= {1'b0, y} + {1'b0, mpf_pkg::PRIME};
        end
        else if (run)
        begin
            x_reg <= {1'b0, x_reg[mpf_pkg::FE_W-1:1]};
        end
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes six and seven are unused; the block answers with zero limbs.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // -p^-1 mod 2^64, the per-limb Montgomery factor.
    localparam logic [63:0] NEG_PINV  = 64'd15580212934572586289;
    localparam int          MAX_GAP   = 13;
    // Allow several times the slowest power with no transfer.
    localparam int          IDLE_LIMIT = 450000;
    localparam int          HOLD_LEN   = 3000;
    localparam int          HOLD_AT    = 30;
    localparam int          N_RANDOM   = 80;

    typedef struct {
        logic [2:0]   op;
        logic [255:0] a;
        logic [255:0] b;
    } field_req_t;

    logic clk;
    logic rst_n;

    mpf_in_if  req_bus ();
    mpf_out_if rsp_bus ();

    montgomery_prime_field_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    field_req_t   request_q[$];
    logic [255:0] predicted_c[$];
    field_req_t   in_flight;

    int mismatches;
    int results_seen;
    int op_count[8];
    int idle_cycles;

    // ------------------------------------------------------------------
    // Field arithmetic predictor
    // ------------------------------------------------------------------

    // Word-serial Montgomery product a*b/2^256, single conditional subtract.
    function automatic logic [255:0] mont_product(logic [255:0] x, logic [255:0] y);
        logic [519:0] t;
        logic [63:0]  m;
        logic [256:0] u;
        t = {264'b0, x} * {264'b0, y};
        for (int i = 0; i < 4; i++)
        begin
            m = t[64*i +: 64] * NEG_PINV;
            t = t + (({456'b0, m} * {264'b0, mpf_pkg::PRIME}) << (64 * i));
        end
        u = t[512:256];
        if (u >= {1'b0, mpf_pkg::PRIME})
            u = u - {1'b0, mpf_pkg::PRIME};
        return u[255:0];
    endfunction

    function automatic logic [255:0] field_result(field_req_t r);
        logic [256:0] s;
        logic [255:0] acc;
        logic [255:0] base;
        case (r.op)
            mpf_pkg::OP_NEG: return (r.a == '0) ? '0 : mpf_pkg::PRIME - r.a;
            mpf_pkg::OP_ADD:
            begin
                s = {1'b0, r.a} + {1'b0, r.b};
                if (s >= {1'b0, mpf_pkg::PRIME})
                    s = s - {1'b0, mpf_pkg::PRIME};
                return s[255:0];
            end
            mpf_pkg::OP_SUB: return (r.a >= r.b) ? r.a - r.b : (mpf_pkg::PRIME - r.b) + r.a;
            mpf_pkg::OP_MUL: return mont_product(r.a, r.b);
            mpf_pkg::OP_SQR: return mont_product(r.a, r.a);
            mpf_pkg::OP_POW:
            begin
                // Right-to-left square-and-multiply from Montgomery one.
                acc  = mpf_pkg::MONT_ONE;
                base = r.a;
                for (int i = 0; i < 256; i++)
                begin
                    if (r.b[i])
                        acc = mont_product(acc, base);
                    base = mont_product(base, base);
                end
                return acc;
            end
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [255:0] rand_wide();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Mostly reduced elements, with edge values and the odd unreduced operand.
    function automatic logic [255:0] pick_operand();
        logic [255:0] v;
        case ($urandom_range(0, 19))
            0:       v = '0;
            1:       v = 256'd1;
            2:       v = mpf_pkg::PRIME - 1;
            3:       v = mpf_pkg::MONT_ONE;
            4:       v = mpf_pkg::PRIME;
            5:       v = '1;
            6:       v = {192'b0, 64'(rand_wide())};
            7:
            begin
                v = rand_wide();
                v[255:192] = 64'hFFFF_FFFF_FFFF_FFFF;
            end
            default:
            begin
                v = rand_wide();
                while (v >= mpf_pkg::PRIME)
                    v = rand_wide();
            end
        endcase
        return v;
    endfunction

    task automatic queue_req(logic [2:0] op, logic [255:0] a, logic [255:0] b);
        field_req_t r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        request_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Count cycles with no transfer on either side; bail out on a hang.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, predicted_c.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driver: pop the next item, hold valid until it transfers,
    // then wait a random gap.
    // ------------------------------------------------------------------

    int send_gap;
    int sent_items;

    always @(posedge clk or negedge rst_n)
    begin
        logic       nxt_valid;
        field_req_t nxt;
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.operation <= mpf_pkg::OP_NEG;
            req_bus.a_limb0   <= '0;
            req_bus.a_limb1   <= '0;
            req_bus.a_limb2   <= '0;
            req_bus.a_limb3   <= '0;
            req_bus.b_limb0   <= '0;
            req_bus.b_limb1   <= '0;
            req_bus.b_limb2   <= '0;
            req_bus.b_limb3   <= '0;
            send_gap          <= 0;
            sent_items        <= 0;
        end
        else
        begin
            nxt_valid = req_bus.valid;
            // Predict the result at the moment the request transfers.
            if (req_bus.valid && req_bus.ready)
            begin
                predicted_c.push_back(field_result(in_flight));
                op_count[in_flight.op] = op_count[in_flight.op] + 1;
                nxt_valid = 1'b0;
                // Leave stretches with no idling every twenty items.
                send_gap <= (sent_items % 20 < 6) ? 0 : $urandom_range(0, MAX_GAP);
                sent_items <= sent_items + 1;
            end
            else if (!req_bus.valid && send_gap > 0)
            begin
                send_gap <= send_gap - 1;
            end
            else if (!req_bus.valid && request_q.size() > 0)
            begin
                nxt = request_q.pop_front();
                in_flight = nxt;
                nxt_valid = 1'b1;
                req_bus.operation <= nxt.op;
                req_bus.a_limb0   <= nxt.a[63:0];
                req_bus.a_limb1   <= nxt.a[127:64];
                req_bus.a_limb2   <= nxt.a[191:128];
                req_bus.a_limb3   <= nxt.a[255:192];
                req_bus.b_limb0   <= nxt.b[63:0];
                req_bus.b_limb1   <= nxt.b[127:64];
                req_bus.b_limb2   <= nxt.b[191:128];
                req_bus.b_limb3   <= nxt.b[255:192];
            end
            req_bus.valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall after each transfer, plus one long
    // hold-off so the request side backs up behind a full output register.
    // ------------------------------------------------------------------

    int   recv_stall;
    int   hold_left;
    logic held_once;

    always @(posedge clk or negedge rst_n)
    begin
        logic [255:0] want;
        logic [255:0] got;
        int           nxt_stall;
        int           nxt_hold;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            recv_stall    <= 0;
            hold_left     <= 0;
            held_once     <= 1'b0;
            results_seen  <= 0;
        end
        else
        begin
            nxt_stall = (recv_stall > 0) ? recv_stall - 1 : 0;
            nxt_hold  = (hold_left > 0) ? hold_left - 1 : 0;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = {rsp_bus.c_limb3, rsp_bus.c_limb2, rsp_bus.c_limb1, rsp_bus.c_limb0};
                if (predicted_c.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: c=%h", got);
                end
                else
                begin
                    want = predicted_c.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got[64*i +: 64] !== want[64*i +: 64])
                        begin
                            mismatches = mismatches + 1;
                            if (mismatches <= 10)
                                $display("result %0d c_limb%0d: expected %h, got %h",
                                         results_seen, i, want[64*i +: 64],
                                         got[64*i +: 64]);
                        end
                    end
                end
                results_seen <= results_seen + 1;
                nxt_stall = (results_seen % 17 < 5) ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == HOLD_AT && !held_once)
                begin
                    nxt_hold = HOLD_LEN;
                    held_once <= 1'b1;
                end
            end
            recv_stall    <= nxt_stall;
            hold_left     <= nxt_hold;
            rsp_bus.ready <= (nxt_stall == 0) && (nxt_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int n_pow;
        logic [2:0]   op;
        logic [255:0] exp_v;
        mismatches  = 0;
        idle_cycles = 0;
        n_pow       = 0;
        for (int i = 0; i < 8; i++)
            op_count[i] = 0;
        rst_n = 1'b0;

        // Directed: edges of every operation.
        queue_req(mpf_pkg::OP_NEG, '0, '1);
        queue_req(mpf_pkg::OP_NEG, 256'd1, '0);
        queue_req(mpf_pkg::OP_NEG, mpf_pkg::PRIME - 1, '0);
        queue_req(mpf_pkg::OP_NEG, '1, '1);
        queue_req(mpf_pkg::OP_ADD, mpf_pkg::PRIME - 1, 256'd1);
        queue_req(mpf_pkg::OP_ADD, mpf_pkg::PRIME - 1, mpf_pkg::PRIME - 1);
        queue_req(mpf_pkg::OP_ADD, '1, '1);
        queue_req(mpf_pkg::OP_ADD, '0, '0);
        queue_req(mpf_pkg::OP_SUB, '0, 256'd1);
        queue_req(mpf_pkg::OP_SUB, mpf_pkg::PRIME - 1, mpf_pkg::PRIME - 1);
        queue_req(mpf_pkg::OP_SUB, '0, '1);
        queue_req(mpf_pkg::OP_SUB, '1, '0);
        queue_req(mpf_pkg::OP_MUL, mpf_pkg::PRIME - 1, mpf_pkg::PRIME - 1);
        queue_req(mpf_pkg::OP_MUL, '1, '1);
        queue_req(mpf_pkg::OP_MUL, mpf_pkg::MONT_ONE, '0);
        queue_req(mpf_pkg::OP_MUL, 256'd1, 256'd1);
        queue_req(mpf_pkg::OP_SQR, mpf_pkg::PRIME - 1, '1);
        queue_req(mpf_pkg::OP_SQR, '1, '0);
        queue_req(mpf_pkg::OP_SQR, '0, '0);
        queue_req(OP_SPARE6, '1, '1);
        queue_req(OP_SPARE7, '1, '1);
        // Power: exponent zero, full-ones exponent, and a short random one.
        queue_req(mpf_pkg::OP_POW, rand_wide() >> 1, '0);
        queue_req(mpf_pkg::OP_POW, mpf_pkg::PRIME - 1, '1);
        queue_req(mpf_pkg::OP_POW, pick_operand(), {192'b0, 64'(rand_wide())});

        // Random: mostly reduced operands; keep power rare since each one is slow.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(0, 49))
                0:       op = (n_pow < 2) ? mpf_pkg::OP_POW : mpf_pkg::OP_MUL;
                1:       op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
                default: op = 3'($urandom_range(0, 4));
            endcase
            if (op == mpf_pkg::OP_POW)
            begin
                n_pow = n_pow + 1;
                // Sparse exponent over all four limbs.
                exp_v = rand_wide() & rand_wide() & rand_wide();
                queue_req(op, pick_operand(), exp_v);
            end
            else
                queue_req(op, pick_operand(), pick_operand());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request out, every prediction matched, then settle.
        while (request_q.size() > 0 || req_bus.valid || predicted_c.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d results: neg %0d add %0d sub %0d mul %0d sqr %0d pow %0d",
                 results_seen, op_count[mpf_pkg::OP_NEG], op_count[mpf_pkg::OP_ADD],
                 op_count[mpf_pkg::OP_SUB], op_count[mpf_pkg::OP_MUL],
                 op_count[mpf_pkg::OP_SQR], op_count[mpf_pkg::OP_POW]);
        $display("unused codes %0d, one long output hold-off, %0d mismatches",
                 op_count[OP_SPARE6] + op_count[OP_SPARE7], mismatches);
        if (mismatches == 0 && predicted_c.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
